// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the port checker, coq_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define COQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define COQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// File: rtl/core/coq_pkg.sv
// ----------------------------------------------------------------------------
// coq_pkg
// Types and constants shared by the cylindrical occupancy query block.
// ----------------------------------------------------------------------------
package coq_pkg;

    localparam int GRID_DEPTH_DEF  = 4096;
    localparam int COORD_BITS_DEF  = 32;
    localparam int COUNT_BITS      = 13;
    localparam int QUOT_BITS       = 13;
    localparam int ADDR_IN_BITS    = 12;
    localparam int CELL_BITS       = 12;
    localparam int ADDR_MAX_BITS   = 20;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int QUEUE_DEPTH     = 4;
    localparam int OUT_DEPTH       = 2;
    localparam int RESULT_BITS     = CELL_BITS + 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_AXIAL_MIN    = 3'd2,
        REG_AXIAL_MAX    = 3'd3,
        REG_RADIUS_MIN   = 3'd4,
        REG_RADIUS_MAX   = 3'd5,
        REG_AXIAL_COUNT  = 3'd6,
        REG_RADIAL_COUNT = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic                     active;
        logic [ADDR_MAX_BITS-1:0] addr;
    } clr_t;

endpackage

// File: rtl/core/cylindrical_occupancy_query_top.sv
// ----------------------------------------------------------------------------
// cylindrical_occupancy_query_top
// One-bit occupancy grid over axial position and radius, with point queries.
// ----------------------------------------------------------------------------
// Channels: s_* takes words (cmd 0 writes cell_address/cell_value, cmd 1
// queries point_x/y/z); m_* returns one word per query (occupied,
// inside_res, cell_found); writes return nothing. cfg_* writes the eight
// registers by index and is always ready; write it only while idle.
// Throughput: one word per cycle in and out when m_ready is held high.
// Pipeline: a query passes through the one-bit-per-stage square root
// (COORD_BITS + 2 stages) and the 13-stage index dividers before the grid read.
// Reset: aresetn clears the control logic and registers, then the grid is
// cleared one cell per cycle over all GRID_DEPTH cells (4096 by default), with
// s_ready low throughout.
// Stall: when m_ready is low and the two-word output queue fills, the compute
// pipeline holds; a four-word input queue keeps s_ready high until it fills.
// ----------------------------------------------------------------------------
module cylindrical_occupancy_query_top #(
    parameter int GRID_DEPTH = coq_pkg::GRID_DEPTH_DEF,
    parameter int COORD_BITS = coq_pkg::COORD_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [coq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [COORD_BITS-1:0]                cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_cmd,
    input  logic [coq_pkg::ADDR_IN_BITS-1:0]     s_cell_address,
    input  logic                                 s_cell_value,
    input  logic signed [COORD_BITS-1:0]         s_point_x,
    input  logic signed [COORD_BITS-1:0]         s_point_y,
    input  logic signed [COORD_BITS-1:0]         s_point_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_occupied,
    output logic                                 m_inside_res,
    output logic [coq_pkg::CELL_BITS-1:0]        m_cell_found
);

    localparam int AW = $clog2(GRID_DEPTH > 1 ? GRID_DEPTH : 2);
    localparam int IW = 3 * COORD_BITS + AW + 2;
    localparam int CW = coq_pkg::COUNT_BITS;

    logic signed [COORD_BITS-1:0] center_x_reg, center_y_reg;
    logic signed [COORD_BITS-1:0] axial_min_reg, axial_max_reg;
    logic [COORD_BITS-2:0]        radius_min_reg, radius_max_reg;
    logic [CW-1:0]                axial_count_reg, radial_count_reg;

    logic                              q_push, q_pop, q_full, q_empty;
    logic [IW-1:0]                     q_in, q_out;
    coq_pkg::clr_t                     clr;
    logic                              o_push, o_full, o_empty;
    logic [coq_pkg::RESULT_BITS-1:0]   o_in, o_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            axial_min_reg    <= '0;
            axial_max_reg    <= '0;
            radius_min_reg   <= '0;
            radius_max_reg   <= '0;
            axial_count_reg  <= CW'(1);
            radial_count_reg <= CW'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (coq_pkg::cfg_reg_t'(cfg_index))
                coq_pkg::REG_CENTER_X:     center_x_reg     <= cfg_data;
                coq_pkg::REG_CENTER_Y:     center_y_reg     <= cfg_data;
                coq_pkg::REG_AXIAL_MIN:    axial_min_reg    <= cfg_data;
                coq_pkg::REG_AXIAL_MAX:    axial_max_reg    <= cfg_data;
                coq_pkg::REG_RADIUS_MIN:   radius_min_reg   <= cfg_data[COORD_BITS-2:0];
                coq_pkg::REG_RADIUS_MAX:   radius_max_reg   <= cfg_data[COORD_BITS-2:0];
                coq_pkg::REG_AXIAL_COUNT:  axial_count_reg  <= cfg_data[CW-1:0];
                coq_pkg::REG_RADIAL_COUNT: radial_count_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    coq_front #(
        .GRID_DEPTH (GRID_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_cell_address (s_cell_address),
        .s_cell_value   (s_cell_value),
        .s_point_x      (s_point_x),
        .s_point_y      (s_point_y),
        .s_point_z      (s_point_z),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_in),
        .clr            (clr)
    );

    coq_fifo #(
        .WIDTH (IW),
        .DEPTH (coq_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    coq_back #(
        .GRID_DEPTH (GRID_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .clr          (clr),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .axial_min    (axial_min_reg),
        .axial_max    (axial_max_reg),
        .radius_min   (radius_min_reg),
        .radius_max   (radius_max_reg),
        .axial_count  (axial_count_reg),
        .radial_count (radial_count_reg),
        .o_full       (o_full),
        .o_push       (o_push),
        .o_data       (o_in)
    );

    coq_fifo #(
        .WIDTH (coq_pkg::RESULT_BITS),
        .DEPTH (coq_pkg::OUT_DEPTH)
    ) u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (o_push),
        .push_data (o_in),
        .pop       (m_valid && m_ready),
        .pop_data  (o_out),
        .full      (o_full),
        .empty     (o_empty)
    );

    assign m_valid      = !o_empty;
    assign m_occupied   = o_out[coq_pkg::RESULT_BITS-1];
    assign m_inside_res = o_out[coq_pkg::RESULT_BITS-2];
    assign m_cell_found = o_out[coq_pkg::CELL_BITS-1:0];

endmodule

// File: rtl/core/coq_ram.sv
// ----------------------------------------------------------------------------
// coq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module coq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/coq_fifo.sv
// ----------------------------------------------------------------------------
// coq_fifo
// Small register queue; decouples accept side from compute side, or compute side from the result port.
// ----------------------------------------------------------------------------
module coq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/coq_front.sv
// ----------------------------------------------------------------------------
// coq_front
// Accepts input words, sorts writes from queries, runs the grid clear sweep.
// ----------------------------------------------------------------------------
module coq_front #(
    parameter int GRID_DEPTH = coq_pkg::GRID_DEPTH_DEF,
    parameter int COORD_BITS = coq_pkg::COORD_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_cmd,
    input  logic [coq_pkg::ADDR_IN_BITS-1:0]     s_cell_address,
    input  logic                                 s_cell_value,
    input  logic signed [COORD_BITS-1:0]         s_point_x,
    input  logic signed [COORD_BITS-1:0]         s_point_y,
    input  logic signed [COORD_BITS-1:0]         s_point_z,
    input  logic                                 q_full,
    output logic                                 q_push,
    output logic [3*COORD_BITS+$clog2(GRID_DEPTH > 1 ? GRID_DEPTH : 2)+1:0] q_data,
    output coq_pkg::clr_t                        clr
);

    localparam int AW = $clog2(GRID_DEPTH > 1 ? GRID_DEPTH : 2);

    logic          clr_active_reg, clr_active_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          accept, is_query, in_range;

    assign s_ready  = !clr_active_reg && !q_full;
    assign accept   = s_valid && s_ready;
    assign is_query = (s_cmd == coq_pkg::CMD_QUERY);
    assign in_range = (32'(s_cell_address) < 32'(GRID_DEPTH));

    // writes beyond the grid are taken and dropped
    assign q_push = accept && (is_query || in_range);
    assign q_data = {is_query, AW'(s_cell_address), s_cell_value,
                     s_point_x, s_point_y, s_point_z};

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            if (clr_addr_reg == AW'(GRID_DEPTH - 1)) begin
                clr_active_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    assign clr.active = clr_active_reg;
    assign clr.addr   = coq_pkg::ADDR_MAX_BITS'(clr_addr_reg);

endmodule

// File: rtl/core/coq_back.sv
// ----------------------------------------------------------------------------
// coq_back
// Query pipeline: radius squared, bit-per-stage square root, bounds,
// restoring dividers for the cell indices, grid RAM access.
// ----------------------------------------------------------------------------
module coq_back #(
    parameter int GRID_DEPTH = coq_pkg::GRID_DEPTH_DEF,
    parameter int COORD_BITS = coq_pkg::COORD_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_empty,
    input  logic [3*COORD_BITS+$clog2(GRID_DEPTH > 1 ? GRID_DEPTH : 2)+1:0] q_data,
    output logic                                 q_pop,
    input  coq_pkg::clr_t                        clr,
    input  logic signed [COORD_BITS-1:0]         center_x,
    input  logic signed [COORD_BITS-1:0]         center_y,
    input  logic signed [COORD_BITS-1:0]         axial_min,
    input  logic signed [COORD_BITS-1:0]         axial_max,
    input  logic [COORD_BITS-2:0]                radius_min,
    input  logic [COORD_BITS-2:0]                radius_max,
    input  logic [coq_pkg::COUNT_BITS-1:0]       axial_count,
    input  logic [coq_pkg::COUNT_BITS-1:0]       radial_count,
    input  logic                                 o_full,
    output logic                                 o_push,
    output logic [coq_pkg::RESULT_BITS-1:0]      o_data
);

    localparam int CB  = COORD_BITS;
    localparam int AW  = $clog2(GRID_DEPTH > 1 ? GRID_DEPTH : 2);
    localparam int IW  = 3 * CB + AW + 2;
    localparam int DW  = CB + 1;
    localparam int HL  = (DW + 1) / 2;
    localparam int HH  = DW - HL;
    localparam int SQW = 2 * DW;
    localparam int SW  = SQW + 2;
    localparam int RW  = SW / 2;
    localparam int OW  = CB;
    localparam int CW  = coq_pkg::COUNT_BITS;
    localparam int MW  = CW + 1;
    localparam int NW  = OW + MW;
    localparam int DNW = OW + 1;
    localparam int QB  = coq_pkg::QUOT_BITS;
    localparam int IXW = 2 * CW + 1;
    localparam int TW  = 3 + AW + OW;
    localparam int S_D = 4 + RW;
    localparam int S_M = 5 + RW;
    localparam int S_I = 6 + RW + QB;
    localparam int S_J = 7 + RW + QB;

    logic en;

    // ---- stage 0 inputs
    logic                 in_isq, in_wval;
    logic [AW-1:0]        in_waddr;
    logic signed [CB-1:0] px, py, pz;
    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0]        ax, ay;
    logic                 z_ok;
    logic [OW-1:0]        offz;

    // config-derived constants
    logic [CW-1:0]  nzc, nrc;
    logic [MW-1:0]  mz, mr;
    logic [OW-1:0]  rngz, rngr;
    logic [DNW-1:0] denz, denr;
    logic           zz, zr;

    logic          valid_reg [S_J+1];
    logic [TW-1:0] tag_reg   [S_J+1];

    logic [DW-1:0]      ax_reg, ay_reg;
    logic [2*HL-1:0]    xll_reg, yll_reg;
    logic [HL+HH-1:0]   xlh_reg, ylh_reg;
    logic [2*HH-1:0]    xhh_reg, yhh_reg;
    logic [SQW-1:0]     sqx_reg, sqy_reg;
    logic [SW-1:0]      sq_rem_reg  [RW+1];
    logic [RW-1:0]      sq_root_reg [RW+1];

    logic [RW-1:0] rr;
    logic          d_ok_reg;
    logic [OW-1:0] d_offr_reg;

    logic [NW-1:0] zr_rem_reg [QB+1];
    logic [QB-1:0] zq_reg     [QB+1];
    logic [NW-1:0] rr_rem_reg [QB+1];
    logic [QB-1:0] rq_reg     [QB+1];
    logic          ok_reg     [QB+1];

    logic [2*CW-1:0] i_prod_reg;
    logic [QB-1:0]   i_qz_reg;
    logic            i_ok_reg;
    logic [IXW-1:0]  idx_sum;
    logic [IXW-1:0]  j_idx_reg;
    logic            j_ok_reg;

    logic                        k_valid_reg, k_ok_reg;
    logic [coq_pkg::CELL_BITS-1:0] k_cell_reg;
    logic                        rdata;
    logic                        ram_we, ram_wval;
    logic [AW-1:0]               ram_waddr;

    assign en    = !o_full;
    assign q_pop = en && !q_empty;

    assign in_isq   = q_data[IW-1];
    assign in_waddr = q_data[IW-2 -: AW];
    assign in_wval  = q_data[3*CB];
    assign px       = q_data[3*CB-1 -: CB];
    assign py       = q_data[2*CB-1 -: CB];
    assign pz       = q_data[CB-1:0];

    always_comb begin
        dx   = DW'(px) - DW'(center_x);
        dy   = DW'(py) - DW'(center_y);
        ax   = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay   = dy[DW-1] ? DW'(-dy) : DW'(dy);
        z_ok = (pz >= axial_min) && (pz <= axial_max);
        offz = OW'(DW'(pz) - DW'(axial_min));
    end

    always_comb begin
        nzc  = (axial_count == '0) ? CW'(1) : axial_count;
        nrc  = (radial_count == '0) ? CW'(1) : radial_count;
        mz   = {nzc - 1'b1, 1'b1};
        mr   = {nrc - 1'b1, 1'b1};
        rngz = OW'(DW'(axial_max) - DW'(axial_min));
        rngr = OW'(radius_max - radius_min);
        denz = {rngz, 1'b0};
        denr = {rngr, 1'b0};
        zz   = (rngz == '0);
        zr   = (rngr == '0);
    end

    // ---- valid and tag line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= S_J; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= q_pop;
            for (int i = 1; i <= S_J; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= {in_isq, in_waddr, in_wval, z_ok, offz};
            for (int i = 1; i <= S_J; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // ---- squares in half-width partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg  <= ax;
            ay_reg  <= ay;
            xll_reg <= ax_reg[HL-1:0] * ax_reg[HL-1:0];
            xlh_reg <= ax_reg[HL-1:0] * ax_reg[DW-1:HL];
            xhh_reg <= ax_reg[DW-1:HL] * ax_reg[DW-1:HL];
            yll_reg <= ay_reg[HL-1:0] * ay_reg[HL-1:0];
            ylh_reg <= ay_reg[HL-1:0] * ay_reg[DW-1:HL];
            yhh_reg <= ay_reg[DW-1:HL] * ay_reg[DW-1:HL];
            sqx_reg <= (SQW'(xhh_reg) << (2 * HL)) + (SQW'(xlh_reg) << (HL + 1))
                       + SQW'(xll_reg);
            sqy_reg <= (SQW'(yhh_reg) << (2 * HL)) + (SQW'(ylh_reg) << (HL + 1))
                       + SQW'(yll_reg);
            sq_rem_reg[0]  <= SW'(sqx_reg) + SW'(sqy_reg);
            sq_root_reg[0] <= '0;
        end
    end

    // ---- integer square root, one root bit per stage
    for (genvar k = 1; k <= RW; k++) begin : g_sqrt
        localparam int B = RW - k;
        logic [SW-1:0] sub;
        logic          take;
        always_comb begin
            sub  = (SW'(sq_root_reg[k-1]) << (B + 1)) | (SW'(1) << (2 * B));
            take = (sq_rem_reg[k-1] >= sub);
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[k]  <= take ? sq_rem_reg[k-1] - sub : sq_rem_reg[k-1];
                sq_root_reg[k] <= take ? (sq_root_reg[k-1] | (RW'(1) << B))
                                       : sq_root_reg[k-1];
            end
        end
    end

    // ---- bounds and offsets
    assign rr = sq_root_reg[RW];

    // upper bound is exact: a root equal to the maximum must leave no remainder
    always_ff @(posedge aclk) begin
        if (en) begin
            d_ok_reg   <= tag_reg[S_D-1][OW] && (rr >= RW'(radius_min))
                          && ((rr < RW'(radius_max))
                              || ((rr == RW'(radius_max)) && (sq_rem_reg[RW] == '0)));
            d_offr_reg <= OW'(rr - RW'(radius_min));
            zr_rem_reg[0] <= NW'(mz) * NW'(tag_reg[S_M-1][OW-1:0]);
            rr_rem_reg[0] <= NW'(mr) * NW'(d_offr_reg);
            zq_reg[0]     <= '0;
            rq_reg[0]     <= '0;
            ok_reg[0]     <= d_ok_reg;
        end
    end

    // ---- restoring dividers, one quotient bit per stage
    for (genvar k = 1; k <= QB; k++) begin : g_div
        localparam int B = QB - k;
        logic [NW-1:0] dz, dr;
        logic          tz, tr;
        always_comb begin
            dz = NW'(denz) << B;
            dr = NW'(denr) << B;
            tz = (zr_rem_reg[k-1] >= dz);
            tr = (rr_rem_reg[k-1] >= dr);
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                zr_rem_reg[k] <= tz ? zr_rem_reg[k-1] - dz : zr_rem_reg[k-1];
                rr_rem_reg[k] <= tr ? rr_rem_reg[k-1] - dr : rr_rem_reg[k-1];
                zq_reg[k]     <= tz ? (zq_reg[k-1] | (QB'(1) << B)) : zq_reg[k-1];
                rq_reg[k]     <= tr ? (rq_reg[k-1] | (QB'(1) << B)) : rq_reg[k-1];
                ok_reg[k]     <= ok_reg[k-1];
            end
        end
    end

    // ---- cell index and depth test
    assign idx_sum = IXW'(i_prod_reg) + IXW'(i_qz_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            i_prod_reg <= (zr ? CW'(0) : CW'(rq_reg[QB])) * nzc;
            i_qz_reg   <= zz ? '0 : zq_reg[QB];
            i_ok_reg   <= ok_reg[QB];
            j_idx_reg  <= idx_sum;
            j_ok_reg   <= i_ok_reg && (32'(idx_sum) < 32'(GRID_DEPTH));
        end
    end

    // ---- grid access; writes and reads meet the RAM at the same stage
    always_comb begin
        if (clr.active) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(clr.addr);
            ram_wval  = 1'b0;
        end else begin
            ram_we    = en && valid_reg[S_J] && !tag_reg[S_J][TW-1];
            ram_waddr = tag_reg[S_J][TW-2 -: AW];
            ram_wval  = tag_reg[S_J][OW+1];
        end
    end

    coq_ram #(
        .WIDTH (1),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wval),
        .re    (en),
        .raddr (AW'(j_idx_reg)),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_valid_reg <= 1'b0;
        end else if (en) begin
            k_valid_reg <= valid_reg[S_J] && tag_reg[S_J][TW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_ok_reg   <= j_ok_reg;
            k_cell_reg <= coq_pkg::CELL_BITS'(j_idx_reg);
        end
    end

    assign o_push = en && k_valid_reg;
    assign o_data = {k_ok_reg & rdata, k_ok_reg,
                     k_ok_reg ? k_cell_reg : coq_pkg::CELL_BITS'(0)};

endmodule

// File: rtl/core/coq_checker.sv
// ----------------------------------------------------------------------------
// coq_checker
// Port-level checks on the occupancy query block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module coq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_occupied,
    input logic                          m_inside_res,
    input logic [coq_pkg::CELL_BITS-1:0] m_cell_found
);

    `COQ_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_occupied) && $stable(m_inside_res) && $stable(m_cell_found))

    `COQ_ASSERT_IMP(a_outside_zero, aclk, aresetn, m_valid && !m_inside_res,
        !m_occupied && (m_cell_found == '0))

    `COQ_ASSERT_IMP(a_occ_inside, aclk, aresetn, m_valid && m_occupied, m_inside_res)

    `COQ_ASSERT_IMP(a_clear_blocks, aclk, aresetn, $rose(aresetn), !s_ready)

endmodule

bind cylindrical_occupancy_query_top coq_checker u_coq_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_occupied   (m_occupied),
    .m_inside_res (m_inside_res),
    .m_cell_found (m_cell_found)
);

// File: dv/cylindrical_occupancy_query_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cylindrical_occupancy_query_checker
// Watches the config, request and result channels of the occupancy query
// block, keeps a shadow grid and register set, predicts each query's word
// and compares results in order against the predicted ones.
// ----------------------------------------------------------------------------
module cylindrical_occupancy_query_checker
    import coq_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_cmd,
    input  logic [ADDR_IN_BITS-1:0]   s_cell_address,
    input  logic                      s_cell_value,
    input  logic [31:0]               s_point_x,
    input  logic [31:0]               s_point_y,
    input  logic [31:0]               s_point_z,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic                      m_occupied,
    input  logic                      m_inside_res,
    input  logic [CELL_BITS-1:0]      m_cell_found,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic                 occupied;
        logic                 in_bounds;
        logic [CELL_BITS-1:0] cell_idx;
    } lookup_t;

    logic    shadow_grid [GRID_DEPTH_DEF];
    longint  cen_x, cen_y, ax_min, ax_max;
    longint unsigned rad_min, rad_max, ax_cnt, rad_cnt;
    lookup_t due_mem [1024];
    int      due_wr, due_rd;

    initial begin
        due_wr = 0;
        due_rd = 0;
    end

    assign pending = due_wr - due_rd;

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic longint unsigned bin_of(longint unsigned offset,
                                               longint unsigned span,
                                               longint unsigned cnt);
        if (span == 0) return 0;
        return ((2 * cnt - 1) * offset) / (2 * span);
    endfunction

    function automatic lookup_t lookup(logic [31:0] px, logic [31:0] py,
                                       logic [31:0] pz);
        lookup_t         res;
        longint          z, dx, dy;
        logic [127:0]    sq, c2;
        longint unsigned r, c, nzc, nrc, nz, nr, idx;
        res = '0;
        z  = longint'($signed(pz));
        dx = longint'($signed(px)) - cen_x;
        dy = longint'($signed(py)) - cen_y;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        if (z > ax_max || z < ax_min) return res;
        if (128'(rad_max) * 128'(rad_max) < sq) return res;
        if (sq < 128'(rad_min) * 128'(rad_min)) return res;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c  = r | (64'd1 << b);
            c2 = 128'(c) * 128'(c);
            if (c2 <= sq) r = c;
        end
        nzc = (ax_cnt == 0) ? 1 : ax_cnt;
        nrc = (rad_cnt == 0) ? 1 : rad_cnt;
        nz  = bin_of(longint'(z - ax_min), longint'(ax_max - ax_min), nzc);
        nr  = bin_of(r - rad_min, rad_max - rad_min, nrc);
        idx = nr * nzc + nz;
        if (idx >= GRID_DEPTH_DEF) return res;
        res.occupied  = shadow_grid[idx];
        res.in_bounds = 1'b1;
        res.cell_idx  = idx[CELL_BITS-1:0];
        return res;
    endfunction

    initial fail_count = 0;

    always @(posedge aclk) begin
        lookup_t exp_w;
        if (!aresetn) begin
            foreach (shadow_grid[i]) shadow_grid[i] = 1'b0;
            cen_x = 0; cen_y = 0; ax_min = 0; ax_max = 0;
            rad_min = 0; rad_max = 0; ax_cnt = 1; rad_cnt = 1;
            due_wr = 0;
            due_rd = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_CENTER_X:     cen_x   = longint'($signed(cfg_data));
                    REG_CENTER_Y:     cen_y   = longint'($signed(cfg_data));
                    REG_AXIAL_MIN:    ax_min  = longint'($signed(cfg_data));
                    REG_AXIAL_MAX:    ax_max  = longint'($signed(cfg_data));
                    REG_RADIUS_MIN:   rad_min = cfg_data[30:0];
                    REG_RADIUS_MAX:   rad_max = cfg_data[30:0];
                    REG_AXIAL_COUNT:  ax_cnt  = cfg_data[COUNT_BITS-1:0];
                    REG_RADIAL_COUNT: rad_cnt = cfg_data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (due_wr == due_rd) begin
                    report("result word with nothing outstanding");
                end else begin
                    exp_w = due_mem[due_rd[9:0]];
                    due_rd++;
                    if (m_occupied !== exp_w.occupied)
                        report($sformatf("occupied %b, want %b", m_occupied,
                                         exp_w.occupied));
                    if (m_inside_res !== exp_w.in_bounds)
                        report($sformatf("inside_res %b, want %b", m_inside_res,
                                         exp_w.in_bounds));
                    if (m_cell_found !== exp_w.cell_idx)
                        report($sformatf("cell_found %0d, want %0d", m_cell_found,
                                         exp_w.cell_idx));
                end
            end
            if (s_valid && s_ready) begin
                if (s_cmd == CMD_WRITE) begin
                    shadow_grid[s_cell_address] = s_cell_value;
                end else begin
                    due_mem[due_wr[9:0]] = lookup(s_point_x, s_point_y, s_point_z);
                    due_wr++;
                end
            end
        end
    end

endmodule

// File: dv/cylindrical_occupancy_query_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cylindrical_occupancy_query_top_tb
// Drives cell writes and point queries into the occupancy query block across
// a series of register settings and flow-control patterns; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module cylindrical_occupancy_query_top_tb;
    import coq_pkg::*;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [31:0]               cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_cmd;
    logic [ADDR_IN_BITS-1:0]   s_cell_address;
    logic                      s_cell_value;
    logic signed [31:0]        s_point_x, s_point_y, s_point_z;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_occupied;
    logic                      m_inside_res;
    logic [CELL_BITS-1:0]      m_cell_found;
    int                        fail_count;
    int                        pending;

    int     send_idle_pct;
    int     stall_pct;
    bit     hold_req;
    longint cx, cy, amin, amax, rmin, rmax;
    int     acnt, rcnt;

    cylindrical_occupancy_query_top u_dut (.*);

    cylindrical_occupancy_query_checker u_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        m_ready  = 1'b0;
        hold_req = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= aresetn && ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_word(input logic cmd, input logic [11:0] addr,
                             input logic val, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_cell_address <= addr;
        s_cell_value   <= val;
        s_point_x      <= px;
        s_point_y      <= py;
        s_point_z      <= pz;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    task automatic program_regs(input longint ncx, input longint ncy,
                                input longint namin, input longint namax,
                                input longint nrmin, input longint nrmax,
                                input int nac, input int nrc);
        drain();
        cx = ncx; cy = ncy; amin = namin; amax = namax;
        rmin = nrmin; rmax = nrmax; acnt = nac; rcnt = nrc;
        cfg_write(REG_CENTER_X, 32'(ncx));
        cfg_write(REG_CENTER_Y, 32'(ncy));
        cfg_write(REG_AXIAL_MIN, 32'(namin));
        cfg_write(REG_AXIAL_MAX, 32'(namax));
        cfg_write(REG_RADIUS_MIN, 32'(nrmin));
        cfg_write(REG_RADIUS_MAX, 32'(nrmax));
        cfg_write(REG_AXIAL_COUNT, 32'(nac));
        cfg_write(REG_RADIAL_COUNT, 32'(nrc));
        cfg_valid <= 1'b0;
    endtask

    function automatic longint pick(longint lo, longint hi);
        longint unsigned span;
        if (hi <= lo) return lo;
        span = longint'(hi - lo) + 1;
        return lo + longint'({$urandom, $urandom} % span);
    endfunction

    task automatic random_word();
        longint rt, dx, dy, lim, zs;
        int     cells;
        cells = acnt * rcnt;
        if (cells < 1 || cells > GRID_DEPTH_DEF) cells = GRID_DEPTH_DEF;
        if ($urandom_range(99) < 35) begin
            if ($urandom_range(99) < 80)
                send_word(CMD_WRITE, 12'($urandom_range(cells - 1)), 1'($urandom),
                          $urandom, $urandom, $urandom);
            else
                send_word(CMD_WRITE, 12'($urandom), 1'($urandom),
                          $urandom, $urandom, $urandom);
        end else if ($urandom_range(99) < 12) begin
            send_word(CMD_QUERY, 12'($urandom), 1'($urandom),
                      $urandom, $urandom, $urandom);
        end else begin
            zs  = (amax > amin) ? (amax - amin) / 8 : 4;
            lim = rmax + rmax / 8 + 2;
            rt  = pick(0, lim);
            dx  = rt * $urandom_range(16) / 16;
            dy  = rt * $urandom_range(16) / 16;
            if ($urandom_range(1)) dx = -dx;
            if ($urandom_range(1)) dy = -dy;
            send_word(CMD_QUERY, 12'($urandom), 1'($urandom), 32'(cx + dx),
                      32'(cy + dy), 32'(pick(amin - zs, amax + zs)));
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_cmd          = CMD_WRITE;
        s_cell_address = '0;
        s_cell_value   = 1'b0;
        s_point_x      = '0;
        s_point_y      = '0;
        s_point_z      = '0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        cx = 0; cy = 0; amin = 0; amax = 0; rmin = 0; rmax = 0;
        acnt = 1; rcnt = 1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset register values
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        send_word(CMD_WRITE, 12'd0, 1'b1, 32'd0, 32'd0, 32'd0);
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'd1, 32'd0, 32'd0);

        program_regs(64'h0010_0000, -64'h0008_0000, -64'h0040_0000, 64'h0040_0000,
                     64'h0001_0000, 64'h0080_0000, 16, 8);
        send_word(CMD_WRITE, 12'd127, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_WRITE, 12'd4095, 1'b1, 32'd0, 32'd0, 32'd0);
        send_word(CMD_WRITE, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        send_word(CMD_QUERY, 12'hFFF, 1'b1, 32'(cx), 32'(cy), 32'd0);
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'(cx + rmax), 32'(cy), 32'(amax));
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'(cx + rmax + 1), 32'(cy), 32'(amax));
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'(cx + rmin), 32'(cy), 32'(amin));
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'(cx), 32'(cy - rmin + 1), 32'(amin));
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'(cx + rmin), 32'(cy), 32'(amin - 1));
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'(cx + rmin), 32'(cy), 32'(amax + 1));
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'(cx + rmax - 1), 32'(cy), 32'(amax - 1));

        // single row along both directions
        program_regs(0, 0, 64'h0002_0000, 64'h0002_0000, 64'h0003_0000,
                     64'h0003_0000, 5, 7);
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'h0003_0000, 32'd0, 32'h0002_0000);
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'd0, -32'sh0003_0000, 32'h0002_0000);
        // min above max
        program_regs(0, 0, 64'h0002_0000, 64'h0001_0000, 64'h0003_0000,
                     64'h0001_0000, 2, 2);
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'h0002_0000, 32'd0, 32'h0001_8000);
        // zero counts
        program_regs(0, 0, 0, 64'h0010_0000, 0, 64'h0010_0000, 0, 0);
        send_word(CMD_QUERY, 12'd0, 1'b0, 32'h0008_0000, 32'd0, 32'h000F_0000);

        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 73; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 73; end
                default: begin send_idle_pct = 25; stall_pct = 25; end
            endcase
            if (ph == 0)
                program_regs(-64'h8000_0000, 64'h7FFF_FFFF, -64'h8000_0000,
                             64'h7FFF_FFFF, 0, 64'h7FFF_FFFF, 4096, 4096);
            else if (ph == 1)
                program_regs(0, 0, 0, 64'h0001_0000, 0, 64'h0001_0000, 4096, 1);
            else if (ph == 2)
                program_regs(0, 0, 0, 64'h0001_0000, 0, 64'h0001_0000, 8191, 8191);
            else if (ph == 5)
                program_regs(0, 0, -64'h0100_0000, 64'h0100_0000, 64'h0000_8000,
                             64'h0200_0000, 64, 64);
            else
                program_regs(longint'($signed($urandom)), longint'($signed($urandom)),
                             pick(-64'h4000_0000, 64'h4000_0000) - 64'h0100_0000,
                             pick(-64'h4000_0000, 64'h4000_0000) + 64'h4100_0000,
                             $urandom_range(32'h0010_0000),
                             64'h0010_0000 + $urandom_range(32'h0400_0000),
                             $urandom_range(1, 64), $urandom_range(1, 64));
            if (ph == 4) hold_req = 1'b1;
            repeat (150) random_word();
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/coq_pkg.sv
rtl/core/coq_ram.sv
rtl/core/coq_fifo.sv
rtl/core/coq_front.sv
rtl/core/coq_back.sv
rtl/core/cylindrical_occupancy_query_top.sv
rtl/core/coq_checker.sv
dv/cylindrical_occupancy_query_checker.sv
dv/cylindrical_occupancy_query_top_tb.sv
